### hw/rtl/lzhm_pkg.sv
// ----------------------------------------------------------------------------
// lzhm_pkg
// Shared types, constants and the three-byte hash of the lz77 hash matcher.
// ----------------------------------------------------------------------------
package lzhm_pkg;

  // default sizes
  localparam int HistoryDepthDef = 8192;
  localparam int HashWidthDef    = 10;
  localparam int LookaheadMaxDef = 128;

  // field and position widths
  localparam int PosW  = 16;
  localparam int DistW = 13;
  localparam int LenW  = 8;
  localparam int CfgW  = 13;

  // register reset values
  localparam logic [DistW-1:0] MaxDistanceRst = 13'd4096;
  localparam logic [LenW-1:0]  MaxMatchRst    = 8'd114;

  // register indexes
  localparam logic CfgMaxDistance = 1'b0;
  localparam logic CfgMaxMatch    = 1'b1;

  // hash multipliers, taken modulo 2^16
  localparam logic [PosW-1:0] HashMul1 = 16'(31321);
  localparam logic [PosW-1:0] HashMul2 = 16'(31321 * 31321);

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_POS,
    ST_HRD1,
    ST_HRD2,
    ST_HEAD,
    ST_CMP,
    ST_LIT,
    ST_EMIT
  } state_e;

  // hash of three bytes modulo 2^16, low bits give any narrower hash
  function automatic logic [PosW-1:0] hash3(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2);
    logic [PosW-1:0] p0;
    logic [PosW-1:0] p1;
    p0 = PosW'({8'd0, b0} * HashMul2);
    p1 = PosW'({8'd0, b1} * HashMul1);
    return p0 + p1 + {8'd0, b2};
  endfunction

endpackage

### hw/rtl/lz77_hash_matcher.sv
// ----------------------------------------------------------------------------
// lz77_hash_matcher
// Greedy lz77 tokenizer with one hash-head table and a history ram.
// ----------------------------------------------------------------------------
// A two-entry input queue feeds a sequencer that handles one item at a time.
// A push that handles no position ends at decode; a handled position reads
// the hash bytes and the head entry, then, for a valid candidate, walks byte
// pairs (up to the copy length plus one, one compare per cycle through the
// dual-read history ram), and its token waits while the previous token is held.
// A position covered by an earlier copy only updates the hash table (nothing
// when fewer than four bytes are left); a literal with fewer than four bytes
// left is read from the history. After reset and every stream end, the hash
// table is wiped over all 2^HASH_WIDTH entries (1024 by default), while no
// item is taken from the queue; configuration writes are taken at any time.
module lz77_hash_matcher #(
  parameter int HISTORY_DEPTH = lzhm_pkg::HistoryDepthDef,
  parameter int HASH_WIDTH    = lzhm_pkg::HashWidthDef,
  parameter int LOOKAHEAD_MAX = lzhm_pkg::LookaheadMaxDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [lzhm_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [7:0]                 data_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       is_copy_o,
  output logic [7:0]                 literal_value_o,
  output logic [lzhm_pkg::DistW-1:0] distance_o,
  output logic [lzhm_pkg::LenW-1:0]  match_len_o,
  output logic                       last_o
);
  import lzhm_pkg::*;

  logic  item_valid;
  item_t item;
  logic  item_pop;

  lzhm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .data_byte_i  (data_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  lzhm_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .HASH_WIDTH    (HASH_WIDTH),
    .LOOKAHEAD_MAX (LOOKAHEAD_MAX)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_pop_o      (item_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_copy_o       (is_copy_o),
    .literal_value_o (literal_value_o),
    .distance_o      (distance_o),
    .match_len_o     (match_len_o),
    .last_o          (last_o)
  );

endmodule

### hw/rtl/lzhm_ram.sv
// ----------------------------------------------------------------------------
// lzhm_ram
// Generic ram, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lzhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### hw/rtl/lzhm_front.sv
// ----------------------------------------------------------------------------
// lzhm_front
// Input side: takes push and drain items into a two-entry queue.
// ----------------------------------------------------------------------------
module lzhm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic [7:0]       data_byte_i,
  output logic             item_valid_o,
  output lzhm_pkg::item_t  item_o,
  input  logic             item_pop_i
);
  import lzhm_pkg::*;

  item_t      slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d;
  logic       wr_q, wr_d;
  logic       push, pop;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && (cnt_q != 2'd0);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_q];

  // queue pointers
  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
    rd_d  = pop ? ~rd_q : rd_q;
    wr_d  = push ? ~wr_q : wr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  // classify and store the transfer
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q].cmd  <= cmd_i ? CMD_DRAIN : CMD_PUSH;
      slot_q[wr_q].data <= data_byte_i;
    end
  end

endmodule

### hw/rtl/lzhm_back.sv
// ----------------------------------------------------------------------------
// lzhm_back
// Sequencer: history, hash table, match walk and token output register.
// ----------------------------------------------------------------------------
module lzhm_back #(
  parameter int HISTORY_DEPTH = lzhm_pkg::HistoryDepthDef,
  parameter int HASH_WIDTH    = lzhm_pkg::HashWidthDef,
  parameter int LOOKAHEAD_MAX = lzhm_pkg::LookaheadMaxDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [lzhm_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                        item_valid_i,
  input  lzhm_pkg::item_t             item_i,
  output logic                        item_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        is_copy_o,
  output logic [7:0]                  literal_value_o,
  output logic [lzhm_pkg::DistW-1:0]  distance_o,
  output logic [lzhm_pkg::LenW-1:0]   match_len_o,
  output logic                        last_o
);
  import lzhm_pkg::*;

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int HD   = 2 ** HASH_WIDTH;
  localparam int LW   = $clog2(LOOKAHEAD_MAX + 1);
  localparam logic [PosW-1:0] DistCap  = PosW'(HISTORY_DEPTH - LOOKAHEAD_MAX - 1);
  localparam logic [PosW-1:0] LookMax  = PosW'(LOOKAHEAD_MAX);
  localparam logic [HASH_WIDTH-1:0] ClrEnd = {HASH_WIDTH{1'b1}};

  state_e                state_q, state_d;
  item_t                 item_q, item_d;
  logic [PosW-1:0]       pp_q, pp_d, pushed_q, pushed_d, look_q, look_d;
  logic [LW-1:0]         skip_q, skip_d, r_q, r_d, limit_q, limit_d, len_q, len_d;
  logic                  draining_q, draining_d;
  logic [7:0]            b0_q, b0_d, b1_q, b1_d, lit_q, lit_d;
  logic [HASH_WIDTH-1:0] h_q, h_d, clr_q, clr_d;
  logic [PosW-1:0]       cand_q, cand_d, dist_q, dist_d;
  logic                  copy_q, copy_d;
  logic [DistW-1:0]      max_dist_q;
  logic [LenW-1:0]       max_match_q;

  logic                  ov_q, ov_d, oc_q, oc_d, olast_q, olast_d;
  logic [7:0]            olit_q, olit_d;
  logic [DistW-1:0]      odist_q, odist_d;
  logic [LenW-1:0]       olen_q, olen_d;

  logic [PosW-1:0]       mm, maxd, pushed_new, d_pos, len_ext;
  logic [PosW-1:0]       h_full;
  logic [HASH_WIDTH-1:0] h_now;

  logic                  hist_we;
  logic [AW-1:0]         hist_ra, hist_rb;
  logic [7:0]            hist_da, hist_db;
  logic                  head_we;
  logic [HASH_WIDTH-1:0] head_wa, head_ra;
  logic [PosW-1:0]       head_wd, head_rd;
  logic [PosW-1:0]       addr_a, addr_b;

  lzhm_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk_i     (clk_i),
    .we_i      (hist_we),
    .waddr_i   (pushed_q[AW-1:0]),
    .wdata_i   (item_q.data),
    .raddr_a_i (hist_ra),
    .rdata_a_o (hist_da),
    .raddr_b_i (hist_rb),
    .rdata_b_o (hist_db)
  );

  lzhm_ram #(.WIDTH(PosW), .DEPTH(HD)) u_heads (
    .clk_i     (clk_i),
    .we_i      (head_we),
    .waddr_i   (head_wa),
    .wdata_i   (head_wd),
    .raddr_a_i (head_ra),
    .rdata_a_o (head_rd),
    .raddr_b_i (head_ra),
    .rdata_b_o ()
  );

  assign hist_ra = addr_a[AW-1:0];
  assign hist_rb = addr_b[AW-1:0];

  // saturated configuration
  always_comb begin
    mm = {8'd0, max_match_q};
    if (mm < 16'd3) mm = 16'd3;
    if (mm > LookMax) mm = LookMax;
    maxd = {3'd0, max_dist_q};
    if (maxd > DistCap) maxd = DistCap;
  end

  assign pushed_new = pushed_q + 16'd1;
  assign h_full     = hash3(b0_q, b1_q, hist_da);
  assign h_now      = h_full[HASH_WIDTH-1:0];
  assign d_pos      = pp_q - head_rd;
  assign len_ext    = PosW'(len_q);

  // next state and datapath control
  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    pp_d       = pp_q;
    pushed_d   = pushed_q;
    look_d     = look_q;
    skip_d     = skip_q;
    r_d        = r_q;
    limit_d    = limit_q;
    len_d      = len_q;
    draining_d = draining_q;
    b0_d       = b0_q;
    b1_d       = b1_q;
    lit_d      = lit_q;
    h_d        = h_q;
    clr_d      = clr_q;
    cand_d     = cand_q;
    dist_d     = dist_q;
    copy_d     = copy_q;
    ov_d       = ov_q && !out_ready_i;
    oc_d       = oc_q;
    olit_d     = olit_q;
    odist_d    = odist_q;
    olen_d     = olen_q;
    olast_d    = olast_q;
    item_pop_o = 1'b0;
    hist_we    = 1'b0;
    head_we    = 1'b0;
    head_wa    = h_q;
    head_wd    = pp_q;
    head_ra    = h_now;
    addr_a     = pp_q;
    addr_b     = pp_q + 16'd1;

    case (state_q)
      // wipe the hash table, then restart the stream
      ST_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_q;
        head_wd = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == ClrEnd) begin
          pp_d       = '0;
          pushed_d   = '0;
          skip_d     = '0;
          draining_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          state_d    = ST_DECODE;
        end
      end
      // store pushed byte and decide whether a position is handled
      ST_DECODE: begin
        if (item_q.cmd == CMD_PUSH) begin
          if (draining_q) begin
            state_d = ST_IDLE;
          end else begin
            hist_we  = 1'b1;
            pushed_d = pushed_new;
            look_d   = pushed_new - pp_q;
            state_d  = (PosW'(pushed_new - pp_q) < mm + 16'd1) ? ST_IDLE : ST_POS;
          end
        end else begin
          draining_d = 1'b1;
          look_d     = pushed_q - pp_q;
          if (pushed_q == pp_q) begin
            clr_d   = '0;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_POS;
          end
        end
      end
      ST_POS: begin
        if (look_q >= 16'd4) begin
          state_d = ST_HRD1;
        end else if (skip_q != '0) begin
          skip_d  = skip_q - 1'b1;
          pp_d    = pp_q + 16'd1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_LIT;
        end
      end
      ST_HRD1: begin
        b0_d    = hist_da;
        b1_d    = hist_db;
        addr_a  = pp_q + 16'd2;
        state_d = ST_HRD2;
      end
      // hash ready: covered positions only update the table
      ST_HRD2: begin
        h_d = h_now;
        if (skip_q != '0) begin
          head_we = 1'b1;
          head_wa = h_now;
          skip_d  = skip_q - 1'b1;
          pp_d    = pp_q + 16'd1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_HEAD;
        end
      end
      // candidate check, start of the match walk
      ST_HEAD: begin
        head_we = 1'b1;
        cand_d  = head_rd;
        dist_d  = d_pos;
        addr_a  = head_rd;
        addr_b  = pp_q;
        limit_d = (look_q < mm) ? look_q[LW-1:0] : mm[LW-1:0];
        r_d     = '0;
        if (d_pos != '0 && d_pos <= maxd) begin
          state_d = ST_CMP;
        end else begin
          copy_d  = 1'b0;
          lit_d   = b0_q;
          state_d = ST_EMIT;
        end
      end
      // one byte pair per pass
      ST_CMP: begin
        addr_a = cand_q + PosW'(r_q) + 16'd1;
        addr_b = pp_q + PosW'(r_q) + 16'd1;
        if (hist_da == hist_db) begin
          r_d = r_q + 1'b1;
          if (r_q + 1'b1 == limit_q) begin
            copy_d  = 1'b1;
            len_d   = limit_q;
            state_d = ST_EMIT;
          end
        end else if (r_q < LW'(3)) begin
          copy_d  = 1'b0;
          lit_d   = b0_q;
          state_d = ST_EMIT;
        end else begin
          copy_d  = 1'b1;
          len_d   = r_q;
          state_d = ST_EMIT;
        end
      end
      ST_LIT: begin
        copy_d  = 1'b0;
        lit_d   = hist_da;
        state_d = ST_EMIT;
      end
      // load the output register once it is free
      ST_EMIT: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          oc_d    = copy_q;
          olit_d  = copy_q ? 8'd0 : lit_q;
          odist_d = copy_q ? dist_q[DistW-1:0] : '0;
          olen_d  = copy_q ? LenW'(len_q) : '0;
          olast_d = 1'b0;
          state_d = ST_IDLE;
          if (copy_q) begin
            if (draining_q && len_ext == look_q) begin
              olast_d = 1'b1;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end else begin
              pp_d   = pp_q + 16'd1;
              skip_d = len_q - 1'b1;
            end
          end else begin
            pp_d = pp_q + 16'd1;
            if (draining_q && look_q == 16'd1) begin
              olast_d = 1'b1;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pp_q        <= '0;
      pushed_q    <= '0;
      skip_q      <= '0;
      draining_q  <= 1'b0;
      ov_q        <= 1'b0;
      max_dist_q  <= MaxDistanceRst;
      max_match_q <= MaxMatchRst;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      pp_q       <= pp_d;
      pushed_q   <= pushed_d;
      skip_q     <= skip_d;
      draining_q <= draining_d;
      ov_q       <= ov_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgMaxDistance: max_dist_q  <= cfg_data_i[DistW-1:0];
          CfgMaxMatch:    max_match_q <= cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    look_q  <= look_d;
    r_q     <= r_d;
    limit_q <= limit_d;
    len_q   <= len_d;
    b0_q    <= b0_d;
    b1_q    <= b1_d;
    lit_q   <= lit_d;
    h_q     <= h_d;
    cand_q  <= cand_d;
    dist_q  <= dist_d;
    copy_q  <= copy_d;
    oc_q    <= oc_d;
    olit_q  <= olit_d;
    odist_q <= odist_d;
    olen_q  <= olen_d;
    olast_q <= olast_d;
  end

  assign out_valid_o     = ov_q;
  assign is_copy_o       = oc_q;
  assign literal_value_o = olit_q;
  assign distance_o      = odist_q;
  assign match_len_o     = olen_q;
  assign last_o          = olast_q;

endmodule

### dv/lz77_hash_matcher_tb.sv
// ----------------------------------------------------------------------------
// lz77_hash_matcher_tb
// Self-checking bench for the lz77 hash matcher: streams of bytes and drains
// are sent through the input channel, every transfer is run through a local
// token predictor, and each output token is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lz77_hash_matcher_tb;
  import lzhm_pkg::*;

  localparam int HistDepth = 8192;
  localparam int HashSize  = 1024;
  localparam int LookMax   = 128;
  localparam int DistCap   = HistDepth - LookMax - 1;
  // up to three queued items, each possibly a full hash table wipe
  localparam int WipeCycles = 3 * (HashSize + 16);

  typedef struct packed {
    logic                 is_copy;
    logic [7:0]           lit;
    logic [DistW-1:0]     back_dist;
    logic [LenW-1:0]      len;
    logic                 last;
  } token_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = 1'b0;
  logic [7:0] data_byte_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic is_copy_o;
  logic [7:0] literal_value_o;
  logic [DistW-1:0] distance_o;
  logic [LenW-1:0] match_len_o;
  logic last_o;

  lz77_hash_matcher i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cmd_i, .data_byte_i,
    .out_valid_o, .out_ready_i, .is_copy_o, .literal_value_o,
    .distance_o, .match_len_o, .last_o
  );

  // predictor state
  logic [7:0]      hist_mem [HistDepth];
  logic [15:0]     head_tbl [HashSize];
  logic [15:0]     proc_pos, push_cnt;
  int unsigned     skip_cnt;
  bit              in_drain;
  int unsigned     cur_max_dist, cur_max_match;

  item_t  pending_items[$];
  token_t expected_tokens[$];
  int     fail_cnt = 0;
  bit     hold_sender = 1'b0;

  initial forever #10 clk_i = ~clk_i;

  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_cnt++;
  endtask

  function automatic logic [7:0] hbyte(input logic [15:0] pos);
    return hist_mem[pos % HistDepth];
  endfunction

  function automatic void clear_stream();
    foreach (head_tbl[i]) head_tbl[i] = '0;
    proc_pos = '0;
    push_cnt = '0;
    skip_cnt = 0;
    in_drain = 1'b0;
  endfunction

  // compute the token, if any, caused by one accepted item
  function automatic void predict_token(input item_t it);
    int unsigned mm, maxd, look, lim, r, h, d;
    logic [15:0] p, cand;
    token_t t;
    mm = cur_max_match < 3 ? 3 : (cur_max_match > LookMax ? LookMax : cur_max_match);
    maxd = cur_max_dist > DistCap ? DistCap : cur_max_dist;
    t = '0;
    h = 0;
    if (it.cmd == CMD_PUSH) begin
      if (in_drain) return;
      hist_mem[push_cnt % HistDepth] = it.data;
      push_cnt = push_cnt + 16'd1;
      look = 16'(push_cnt - proc_pos);
      if (look < mm + 1) return;
    end else begin
      in_drain = 1'b1;
      look = 16'(push_cnt - proc_pos);
      if (look == 0) begin
        clear_stream();
        return;
      end
    end
    p = proc_pos;
    if (look >= 4)
      h = (hbyte(p) * 31321 * 31321 + hbyte(p + 16'd1) * 31321 + hbyte(p + 16'd2)) % HashSize;
    // position covered by a copy
    if (skip_cnt > 0) begin
      if (look >= 4) head_tbl[h] = p;
      skip_cnt--;
      proc_pos = p + 16'd1;
      return;
    end
    if (look >= 4) begin
      cand = head_tbl[h];
      d = 16'(p - cand);
      if (d >= 1 && d <= maxd && hbyte(cand) == hbyte(p) &&
          hbyte(cand + 16'd1) == hbyte(p + 16'd1) &&
          hbyte(cand + 16'd2) == hbyte(p + 16'd2)) begin
        lim = look < mm ? look : mm;
        r = 3;
        while (r < lim && hbyte(16'(cand + r)) == hbyte(16'(p + r))) r++;
        t.is_copy = 1'b1;
        t.back_dist = DistW'(d);
        t.len = LenW'(r);
      end
      head_tbl[h] = p;
    end
    if (t.is_copy) begin
      if (in_drain && t.len == look) t.last = 1'b1;
      else begin
        proc_pos = p + 16'd1;
        skip_cnt = t.len - 1;
      end
    end else begin
      t.lit = hbyte(p);
      proc_pos = p + 16'd1;
      if (in_drain && look == 1) t.last = 1'b1;
    end
    if (t.last) clear_stream();
    expected_tokens.push_back(t);
  endfunction

  // driver: bursts of transfers separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_token(pending_items.pop_front());
    end
    if (in_valid_i && !in_ready_o) begin
      // hold until accepted
    end else if (pending_items.size() > 0 && !hold_sender && gap_left == 0) begin
      in_valid_i <= 1'b1;
      cmd_i <= pending_items[0].cmd;
      data_byte_i <= pending_items[0].data;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end else begin
      in_valid_i <= 1'b0;
      if (gap_left > 0) gap_left--;
    end
  end

  // monitor and receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk_i) begin
    token_t got, exp_tok;
    if (out_valid_o && out_ready_i) begin
      got = '{is_copy_o, literal_value_o, distance_o, match_len_o, last_o};
      if (expected_tokens.size() == 0) begin
        report($sformatf("unexpected token %p", got));
      end else begin
        exp_tok = expected_tokens.pop_front();
        if (got.is_copy !== exp_tok.is_copy)
          report($sformatf("is_copy %0d exp %0d", got.is_copy, exp_tok.is_copy));
        if (got.lit !== exp_tok.lit)
          report($sformatf("literal_value %0d exp %0d", got.lit, exp_tok.lit));
        if (got.back_dist !== exp_tok.back_dist)
          report($sformatf("distance %0d exp %0d", got.back_dist, exp_tok.back_dist));
        if (got.len !== exp_tok.len)
          report($sformatf("match_len %0d exp %0d", got.len, exp_tok.len));
        if (got.last !== exp_tok.last)
          report($sformatf("last %0d exp %0d", got.last, exp_tok.last));
      end
    end
    stall_phase = (stall_phase + 1) % 512;
    if (stall_phase < 128) out_ready_i <= 1'b1;
    else if (stall_phase < 256) out_ready_i <= ($urandom_range(0, 3) != 0);
    else out_ready_i <= (stall_phase % 7) < 3 || $urandom_range(0, 1);
  end

  task automatic push_byte(input logic [7:0] b);
    pending_items.push_back('{CMD_PUSH, b});
  endtask

  task automatic drain_all(input int n);
    repeat (n) pending_items.push_back('{CMD_DRAIN, 8'h00});
  endtask

  // wait until the block has taken and answered everything
  task automatic wait_quiet();
    while (pending_items.size() > 0 || in_valid_i || expected_tokens.size() > 0)
      @(posedge clk_i);
    repeat (WipeCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMaxDistance) cur_max_dist = val & 13'h1FFF;
    else cur_max_match = val & 8'hFF;
  endtask

  // one stream built from repeated fragments so copies are common
  task automatic gen_stream(input int n);
    logic [7:0] frag[$];
    int len;
    for (int i = 0; i < n; i++) begin
      if (frag.size() > 3 && $urandom_range(0, 2) != 0) begin
        len = $urandom_range(3, frag.size() > 140 ? 140 : frag.size());
        for (int j = 0; j < len && i < n; j++, i++) push_byte(frag[j]);
        i--;
      end else begin
        frag.push_back(8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(65, 68)));
        push_byte(frag[frag.size() - 1]);
      end
    end
    // occasional stray pushes during drain and extra empty drains
    drain_all(1);
    if ($urandom_range(0, 3) == 0) push_byte(8'($urandom));
    drain_all(n + 2);
  endtask

  initial begin
    int sent;
    int unsigned dists[5];
    int unsigned match_cfgs[5];
    dists = '{1, 17, 300, 4096, 8191};
    match_cfgs = '{3, 128, 0, 255, 10};
    hist_mem = '{default: '0};
    clear_stream();
    cur_max_dist = MaxDistanceRst;
    cur_max_match = MaxMatchRst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (WipeCycles) @(posedge clk_i);

    // directed: literals, extremes, a long run, drain with nothing, one-byte stream
    drain_all(1);
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h55); push_byte(8'hAA);
    repeat (8) push_byte(8'h00);
    drain_all(14);
    push_byte(8'h11);
    drain_all(1);
    wait_quiet();
    hold_sender = 1'b0;

    sent = 0;
    for (int k = 0; k < 5; k++) begin
      write_reg(CfgMaxDistance, dists[k]);
      write_reg(CfgMaxMatch, match_cfgs[k]);
      while (sent < 370 * (k + 1)) begin
        int n;
        n = $urandom_range(4, k == 1 ? 200 : 60);
        gen_stream(n);
        sent += 2 * n;
        if ($urandom_range(0, 5) == 0) begin
          hold_sender = 1'b1;
          while (expected_tokens.size() > 0 || in_valid_i) @(posedge clk_i);
          hold_sender = 1'b0;
        end
      end
      wait_quiet();
    end

    if (fail_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
